FILE: sv/fssp_pkg.sv
// ---------------------------------------------------------------------------
// fssp_pkg
// Shared widths, opcodes, result kinds, register indexes and the structs
// that travel between the parser stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fssp_pkg;

  // Fixed field widths
  localparam int OP_W       = 3;
  localparam int SYM_W      = 8;
  localparam int KIND_W     = 3;
  localparam int RES_LEN_W  = 48;
  localparam int LINE_W     = 32;
  localparam int RUN_W      = 32;
  localparam int RES_CNT_W  = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Default sizes for the top-level parameters
  localparam int DEF_ALPHABET_SIZE = 256;
  localparam int DEF_COUNT_WIDTH   = 40;
  localparam int DEF_LENGTH_WIDTH  = 48;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA = 3'd1;
  localparam logic [OP_W-1:0] OP_EOF  = 3'd2;
  localparam logic [OP_W-1:0] OP_END  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOTALS  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NO_SEQ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_FORMAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNDEFINED_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_FROM   = 3'd4;

  // Characters the parser looks for
  localparam logic [SYM_W-1:0] CHAR_GT    = 8'h3E;
  localparam logic [SYM_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic             plain_format;
    logic             map_enabled;
    logic [SYM_W-1:0] separator_code;
    logic [SYM_W-1:0] undefined_code;
    logic [SYM_W-1:0] special_from;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    plain_format:   1'b0,
    map_enabled:    1'b1,
    separator_code: 8'd255,
    undefined_code: 8'd253,
    special_from:   8'd254
  };

  // Result fields known after the parse stage
  typedef struct packed {
    logic                 vld;
    logic [KIND_W-1:0]    kind;
    logic [SYM_W-1:0]     symbol;
    logic [RES_LEN_W-1:0] raw_length;
    logic [RES_LEN_W-1:0] effective_length;
    logic [LINE_W-1:0]    line_number;
    logic [RUN_W-1:0]     special_run;
  } res_t;

  // Histogram access requested by the parse stage
  typedef struct packed {
    logic             rd;
    logic             inc;
    logic [SYM_W-1:0] addr;
  } hist_req_t;

endpackage

FILE: sv/fssp_ifs.sv
// ---------------------------------------------------------------------------
// fssp channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fssp_in_if import fssp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [SYM_W-1:0] byte_value;
  logic [SYM_W-1:0] map_code;

  modport source (output valid, output opcode, output byte_value, output map_code,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input map_code,
                  output ready);
endinterface

interface fssp_out_if import fssp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SYM_W-1:0]     symbol;
  logic [RES_LEN_W-1:0] raw_length;
  logic [RES_LEN_W-1:0] effective_length;
  logic [LINE_W-1:0]    line_number;
  logic [RES_CNT_W-1:0] code_count;
  logic [RUN_W-1:0]     special_run;

  modport source (output valid, output kind, output symbol, output raw_length,
                  output effective_length, output line_number, output code_count,
                  output special_run, input ready);
  modport sink   (input valid, input kind, input symbol, input raw_length,
                  input effective_length, input line_number, input code_count,
                  input special_run, output ready);
endinterface

interface fssp_cfg_if import fssp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/fssp_symmap.sv
// ---------------------------------------------------------------------------
// fssp_symmap
// 256-entry symbol map RAM, one shared address, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fssp_symmap import fssp_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [SYM_W-1:0] addr,
  input  logic [SYM_W-1:0] wdata,
  output logic [SYM_W-1:0] rdata
);

  localparam int Depth = 1 << SYM_W;

  logic [SYM_W-1:0] map_mem [Depth];
  logic [SYM_W-1:0] rdata_r;

  // Write on map load, read on every accepted item
  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= map_mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/fssp_parse.sv
// ---------------------------------------------------------------------------
// fssp_parse
// Parse stage: holds the per-file and global scalar state, decodes one item
// per cycle while not stalled, using the mapped code, and produces the result
// and histogram request for the next stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fssp_parse import fssp_pkg::*; #(
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int LENGTH_WIDTH  = DEF_LENGTH_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld,
  input  logic [OP_W-1:0]  op,
  input  logic [SYM_W-1:0] byte_in,
  input  logic [SYM_W-1:0] map_code,
  input  cfg_t             cfg,
  output res_t             res,
  output hist_req_t        req
);

  localparam int CmpW = SYM_W + 1;

  logic                    in_header_r, in_header_nxt;
  logic                    first_overall_r, first_overall_nxt;
  logic                    first_in_file_r, first_in_file_nxt;
  logic                    any_plain_r, any_plain_nxt;
  logic [LINE_W-1:0]       line_r, line_nxt;
  logic [RUN_W-1:0]        special_r, special_nxt;
  logic [LENGTH_WIDTH-1:0] raw_r, raw_nxt;
  logic [LENGTH_WIDTH-1:0] eff_r, eff_nxt;

  logic [LENGTH_WIDTH-1:0] raw_inc, eff_inc;
  logic [LINE_W-1:0]       line_inc;
  logic [RUN_W-1:0]        special_inc;
  logic                    is_blank;
  logic                    code_in_alpha;
  logic                    byte_in_alpha;

  // Saturating increments
  assign raw_inc     = (raw_r == '1) ? raw_r : raw_r + LENGTH_WIDTH'(1);
  assign eff_inc     = (eff_r == '1) ? eff_r : eff_r + LENGTH_WIDTH'(1);
  assign line_inc    = (line_r == '1) ? line_r : line_r + LINE_W'(1);
  assign special_inc = (special_r == '1) ? special_r : special_r + RUN_W'(1);

  assign is_blank = (byte_in == CHAR_SPACE) || ((byte_in >= CHAR_TAB) && (byte_in <= CHAR_CR));
  assign code_in_alpha = (CmpW'({1'b0, map_code}) < CmpW'(ALPHABET_SIZE));
  assign byte_in_alpha = (CmpW'({1'b0, byte_in}) < CmpW'(ALPHABET_SIZE));

  // Decode the item and compute next state
  always_comb begin
    in_header_nxt     = in_header_r;
    first_overall_nxt = first_overall_r;
    first_in_file_nxt = first_in_file_r;
    any_plain_nxt     = any_plain_r;
    line_nxt          = line_r;
    special_nxt       = special_r;
    raw_nxt           = raw_r;
    eff_nxt           = eff_r;
    res               = '0;
    req               = '0;
    if (vld) begin
      unique case (op)
        OP_DATA: begin
          raw_nxt = raw_inc;
          if (cfg.plain_format) begin
            eff_nxt       = eff_inc;
            any_plain_nxt = 1'b1;
            res.vld       = 1'b1;
            res.symbol    = byte_in;
          end else if (byte_in == CHAR_NL) begin
            line_nxt      = line_inc;
            in_header_nxt = 1'b0;
          end else if (!in_header_r && !is_blank) begin
            if (byte_in == CHAR_GT) begin
              in_header_nxt = 1'b1;
              if (first_overall_r) begin
                first_overall_nxt = 1'b0;
                first_in_file_nxt = 1'b0;
              end else begin
                if (first_in_file_r) begin
                  first_in_file_nxt = 1'b0;
                end else begin
                  eff_nxt = eff_inc;
                end
                special_nxt = special_inc;
                res.vld     = 1'b1;
                res.symbol  = cfg.separator_code;
              end
            end else if (!cfg.map_enabled) begin
              eff_nxt    = eff_inc;
              res.vld    = 1'b1;
              res.symbol = byte_in;
            end else if (map_code == cfg.undefined_code) begin
              res.vld  = 1'b1;
              res.kind = KIND_ILLEGAL;
            end else begin
              if (map_code >= cfg.special_from) begin
                special_nxt = special_inc;
              end else begin
                special_nxt = '0;
                if (code_in_alpha) begin
                  req.rd   = 1'b1;
                  req.inc  = 1'b1;
                  req.addr = map_code;
                end
              end
              eff_nxt    = eff_inc;
              res.vld    = 1'b1;
              res.symbol = map_code;
            end
          end
        end
        OP_EOF: begin
          res.vld              = 1'b1;
          res.kind             = KIND_TOTALS;
          res.raw_length       = RES_LEN_W'(raw_r);
          res.effective_length = RES_LEN_W'(eff_r);
          raw_nxt              = '0;
          eff_nxt              = '0;
          line_nxt             = LINE_W'(1);
          in_header_nxt        = 1'b0;
          first_in_file_nxt    = 1'b1;
        end
        OP_END: begin
          res.vld = 1'b1;
          if (cfg.plain_format ? !any_plain_r : first_overall_r) begin
            res.kind = KIND_NO_SEQ;
          end else begin
            res.kind = KIND_DONE;
          end
        end
        OP_READ: begin
          res.vld  = 1'b1;
          res.kind = KIND_COUNT;
          if (byte_in_alpha) begin
            req.rd   = 1'b1;
            req.addr = byte_in;
          end
        end
        default: begin
        end
      endcase
    end
    res.line_number = line_r;
    res.special_run = special_nxt;
  end

  // Hold state while stalled, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r     <= 1'b0;
      first_overall_r <= 1'b1;
      first_in_file_r <= 1'b1;
      any_plain_r     <= 1'b0;
      line_r          <= LINE_W'(1);
      special_r       <= '0;
      raw_r           <= '0;
      eff_r           <= '0;
    end else if (adv) begin
      in_header_r     <= in_header_nxt;
      first_overall_r <= first_overall_nxt;
      first_in_file_r <= first_in_file_nxt;
      any_plain_r     <= any_plain_nxt;
      line_r          <= line_nxt;
      special_r       <= special_nxt;
      raw_r           <= raw_nxt;
      eff_r           <= eff_nxt;
    end
  end

  // The first header of the input always opens a header and closes the
  // first-in-file window
  a_first_header: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_overall_r) |-> (!first_in_file_r && in_header_r))
    else $error("first header did not update file state");

endmodule

FILE: sv/fssp_hist.sv
// ---------------------------------------------------------------------------
// fssp_hist
// Histogram stage: code histogram RAM with per-entry valid bits, registered
// read, saturating increment and write back, with a forwarding register for
// back-to-back updates of the same code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fssp_hist import fssp_pkg::*; #(
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  res_t                 res_in,
  input  hist_req_t            req_in,
  output res_t                 res_out,
  output logic [RES_CNT_W-1:0] count_out
);

  localparam int AddrW = $clog2(ALPHABET_SIZE);

  logic [COUNT_WIDTH-1:0]   hist_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] hv_r;

  res_t                   s2_res_r;
  hist_req_t              s2_req_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_hv_r;

  logic                   fwd_vld_r;
  logic [AddrW-1:0]       fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  logic [AddrW-1:0]       rd_addr;
  logic [AddrW-1:0]       s2_addr;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic                   wr_en;

  assign rd_addr = req_in.addr[AddrW-1:0];
  assign s2_addr = s2_req_r.addr[AddrW-1:0];
  assign wr_en   = adv && s2_req_r.inc;

  // Current count: forward the write of the previous step, else stored value if valid, else zero
  assign base    = (fwd_vld_r && (fwd_addr_r == s2_addr)) ? fwd_data_r :
                   (rd_hv_r ? rd_data_r : '0);
  assign inc_val = (base == '1) ? base : base + COUNT_WIDTH'(1);

  // Stage registers and forwarding state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_res_r  <= '0;
      s2_req_r  <= '0;
      fwd_vld_r <= 1'b0;
      hv_r      <= '0;
    end else if (adv) begin
      s2_res_r  <= res_in;
      s2_req_r  <= req_in;
      fwd_vld_r <= s2_req_r.inc;
      if (s2_req_r.inc) begin
        hv_r[s2_addr] <= 1'b1;
      end
    end
  end

  // Memory read, write back and forwarding payload
  always_ff @(posedge clk) begin
    if (adv && req_in.rd) begin
      rd_data_r <= hist_mem[rd_addr];
      rd_hv_r   <= hv_r[rd_addr];
    end
    if (wr_en) begin
      hist_mem[s2_addr] <= inc_val;
      fwd_addr_r        <= s2_addr;
      fwd_data_r        <= inc_val;
    end
  end

  assign res_out   = s2_res_r;
  assign count_out = (s2_req_r.rd && !s2_req_r.inc) ? RES_CNT_W'(base) : '0;

  a_inc_has_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    s2_req_r.inc |-> (s2_res_r.vld && (s2_res_r.kind == KIND_SYMBOL)))
    else $error("histogram update without a symbol result");

  a_read_is_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_req_r.rd && !s2_req_r.inc) |-> (s2_res_r.vld && (s2_res_r.kind == KIND_COUNT)))
    else $error("histogram read without a count result");

  a_fwd_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> hv_r[fwd_addr_r])
    else $error("forwarded entry not marked valid");

endmodule

FILE: sv/fasta_symbol_stream_parser.sv
// ---------------------------------------------------------------------------
// fasta_symbol_stream_parser
// Multi-FASTA byte stream parser. Takes one item per cycle, back to back,
// while no waiting result stalls the pipeline: the accepted item has its
// symbol map entry read into the parse stage, where header skipping, line,
// length and special run counting happen, then the code histogram is
// read-modified-written in the histogram stage, and the result sits in the
// output register. The histogram update path (map RAM read, histogram RAM
// read, increment, write back with forwarding of the previous write) sets
// the one-item-per-cycle rate. Items that give no result (map loads,
// newlines, header and blank bytes) leave bubbles that do not block later
// results. The histogram needs no clearing pass after reset: each entry has
// a valid bit cleared by reset. Register writes are accepted every cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fasta_symbol_stream_parser import fssp_pkg::*; #(
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
  parameter int LENGTH_WIDTH  = DEF_LENGTH_WIDTH
) (
  input  logic   clk,
  input  logic   rst_n,
  fssp_in_if.sink     in_stream,
  fssp_out_if.source  out_stream,
  fssp_cfg_if.sink    cfg_wr
);

  cfg_t             cfg_r;
  logic             adv;
  logic             in_acc;

  logic             s1_vld_r;
  logic [OP_W-1:0]  s1_op_r;
  logic [SYM_W-1:0] s1_byte_r;
  logic [SYM_W-1:0] map_rdata;

  res_t             s1_res;
  hist_req_t        s1_req;
  res_t             s2_res;
  logic [RES_CNT_W-1:0] s2_count;

  logic                 out_valid_r;
  res_t                 out_res_r;
  logic [RES_CNT_W-1:0] out_count_r;

  // Pipeline moves unless a waiting result would be overwritten
  assign adv    = !out_valid_r || out_stream.ready || !s2_res.vld;
  assign in_acc = in_stream.valid && adv;
  assign in_stream.ready = adv;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_PLAIN_FORMAT:   cfg_r.plain_format   <= cfg_wr.data[0];
        REG_MAP_ENABLED:    cfg_r.map_enabled    <= cfg_wr.data[0];
        REG_SEPARATOR_CODE: cfg_r.separator_code <= cfg_wr.data;
        REG_UNDEFINED_CODE: cfg_r.undefined_code <= cfg_wr.data;
        REG_SPECIAL_FROM:   cfg_r.special_from   <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  // Symbol map: load on opcode 0, read for every accepted item
  fssp_symmap u_symmap (
    .clk   (clk),
    .we    (in_acc && (in_stream.opcode == OP_LOAD)),
    .re    (in_acc),
    .addr  (in_stream.byte_value),
    .wdata (in_stream.map_code),
    .rdata (map_rdata)
  );

  // Parse stage item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_stream.opcode;
      s1_byte_r <= in_stream.byte_value;
    end
  end

  fssp_parse #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld      (s1_vld_r),
    .op       (s1_op_r),
    .byte_in  (s1_byte_r),
    .map_code (map_rdata),
    .cfg      (cfg_r),
    .res      (s1_res),
    .req      (s1_req)
  );

  fssp_hist #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res_in    (s1_res),
    .req_in    (s1_req),
    .res_out   (s2_res),
    .count_out (s2_count)
  );

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_res.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_res.vld) begin
      out_res_r   <= s2_res;
      out_count_r <= s2_count;
    end
  end

  assign out_stream.valid            = out_valid_r;
  assign out_stream.kind             = out_res_r.kind;
  assign out_stream.symbol           = out_res_r.symbol;
  assign out_stream.raw_length       = out_res_r.raw_length;
  assign out_stream.effective_length = out_res_r.effective_length;
  assign out_stream.line_number      = out_res_r.line_number;
  assign out_stream.code_count       = out_count_r;
  assign out_stream.special_run      = out_res_r.special_run;

  // A waiting result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stream.ready && s2_res.vld) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result overwritten");

endmodule
